/* src/serial_image_load_framer_macros.svh */
// ----------------------------------------------------------------------------
// Serial image load framer assertion macros
// Concurrent assertion helpers shared by the framer RTL files.
// ----------------------------------------------------------------------------
`ifndef SERIAL_IMAGE_LOAD_FRAMER_MACROS_SVH
`define SERIAL_IMAGE_LOAD_FRAMER_MACROS_SVH
`ifndef SYNTH
`define SILF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SILF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SILF_ASSERT(lbl, prop, msg)
`define SILF_NEVER(lbl, expr, msg)
`endif
`endif

/* src/silf_pkg.sv */
// ----------------------------------------------------------------------------
// Serial image load framer package
// Result codes, register indexes, result types and the percent helper.
// ----------------------------------------------------------------------------
`default_nettype none

package silf_pkg;

  localparam int unsigned PCT_W = 7;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd127;

  localparam logic [1:0] HDR_LAST = 2'd3;

  localparam logic [1:0] STAT_HEADER = 2'd0;
  localparam logic [1:0] STAT_BAD_MAGIC = 2'd1;
  localparam logic [1:0] STAT_DATA = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE = 8'd1;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      addr;
    logic [7:0]       data;
    logic             pvalid;
    logic [PCT_W-1:0] pct;
    logic             done;
  } result_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PCT_W-1:0] quotient;
  } div_res_t;

  function automatic logic is_tenth(input logic [PCT_W-1:0] p);
    is_tenth = (p == 7'd0) || (p == 7'd10) || (p == 7'd20) || (p == 7'd30) ||
               (p == 7'd40) || (p == 7'd50) || (p == 7'd60) || (p == 7'd70) ||
               (p == 7'd80) || (p == 7'd90) || (p == 7'd100) || (p == 7'd110) ||
               (p == 7'd120);
  endfunction

endpackage

`default_nettype wire

/* src/silf_pct_div.sv */
// ----------------------------------------------------------------------------
// Serial percent divider
// Restoring divider that develops one quotient bit per cycle. The quotient
// is known to stay below 128, so seven steps cover it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_image_load_framer_macros.svh"

module silf_pct_div #(
  parameter int unsigned LB = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [LB+silf_pkg::PCT_W-1:0]   dividend_i,
  input  wire logic [LB-1:0]                   divisor_i,
  output silf_pkg::div_res_t                   res_o
);

  localparam int unsigned DW = LB + silf_pkg::PCT_W;
  localparam int unsigned QW = silf_pkg::PCT_W;
  localparam int unsigned CW = $clog2(QW);

  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dsh_q, dsh_d;
  logic [LB-1:0] divisor_q, divisor_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          ge;

  assign ge = rem_q >= dsh_q;

  always_comb begin
    rem_d = rem_q;
    dsh_d = dsh_q;
    divisor_d = divisor_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i;
      dsh_d = {1'b0, divisor_i, {(QW-1){1'b0}}};
      divisor_d = divisor_i;
      quo_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[QW-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(QW-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    divisor_q <= divisor_d;
    quo_q <= quo_d;
  end

  assign res_o.busy = busy_q;
  assign res_o.done = done_q;
  assign res_o.quotient = quo_q;

  `SILF_ASSERT(a_start_when_free, start_i |-> !busy_q, "divider started while busy")
  `SILF_ASSERT(a_divisor_nonzero, busy_q |-> (divisor_q != '0), "divide by zero length")
  `SILF_ASSERT(a_quotient_range, done_q |-> (quo_q <= silf_pkg::PCT_FULL), "percent above full")

endmodule

`default_nettype wire

/* src/serial_image_load_framer.sv */
// ----------------------------------------------------------------------------
// Serial image load framer
// Frames a boot image received one byte per item: magic word check, image
// length, then one memory write per data byte with ten-percent progress.
//
//   Channel   Dir  Handshake                    Content
//   s_axis    in   tvalid/tready                tdata: rx byte
//   m_axis    out  tvalid/tready                tdata: address, data, percent
//                                               tuser: status, progress flag
//                                               tlast: load complete
//   cfg       in   cfg_we_i                     0 magic word, 1 load base
//
// A header byte passes through S_IDLE and S_FIN; a data byte also passes through
// S_DIV, where the seven-step serial divider forms the progress percent.
// Reset clears all control state and the registers; no clearing pass.
// A result waits in the output register while the next item is accepted;
// the item after that waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_image_load_framer_macros.svh"

module serial_image_load_framer #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [silf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [63:0]                      cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [63:0] write_addr, [71:64] write_data, [78:72] progress_percent, [79] zero
  output      logic [79:0]                      m_axis_tdata,
  output      logic [2:0]                       m_axis_tuser,  // [1:0] status, [2] progress_valid
  output      logic                             m_axis_tlast   // done_res
);

  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned DW = LB + silf_pkg::PCT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_MAGIC,
    PH_LENGTH,
    PH_DATA
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [1:0] hdr_cnt_q, hdr_cnt_d;
  logic [31:0] magic_sr_q, magic_sr_d;
  logic [31:0] len_sr_q, len_sr_d;
  logic [LB-1:0] idx_q, idx_d;
  logic [silf_pkg::PCT_W-1:0] last_pct_q, last_pct_d;
  logic [31:0] magic_word_q;
  logic [63:0] load_base_q;
  silf_pkg::result_t res_q, res_d;
  silf_pkg::result_t out_q, out_d;
  logic m_valid_q, m_valid_d;

  logic [31:0] magic_shift;
  logic [31:0] len_shift;
  logic [LB-1:0] idx_next;
  logic [DW-1:0] dividend;
  logic div_start;
  silf_pkg::div_res_t div_res;

  assign magic_shift = {s_axis_tdata, magic_sr_q[31:8]};
  assign len_shift = {s_axis_tdata, len_sr_q[31:8]};
  assign idx_next = idx_q + LB'(1);
  assign dividend = DW'(idx_next) * DW'(silf_pkg::PCT_FULL);
  assign s_axis_tready = (state_q == S_IDLE);

  silf_pct_div #(
    .LB (LB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (len_sr_q[LB-1:0]),
    .res_o      (div_res)
  );

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    magic_sr_d = magic_sr_q;
    len_sr_d = len_sr_q;
    idx_d = idx_q;
    last_pct_d = last_pct_q;
    res_d = res_q;
    out_d = out_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_d = '0;
          state_d = S_FIN;
          case (phase_q)
            PH_LENGTH: begin
              len_sr_d = len_shift;
              if (hdr_cnt_q == silf_pkg::HDR_LAST) begin
                hdr_cnt_d = '0;
                idx_d = '0;
                last_pct_d = silf_pkg::PCT_NONE;
                if (len_shift[LB-1:0] == '0) begin
                  res_d.status = silf_pkg::STAT_EMPTY;
                  res_d.done = 1'b1;
                  phase_d = PH_MAGIC;
                end else begin
                  phase_d = PH_DATA;
                end
              end else begin
                hdr_cnt_d = hdr_cnt_q + 2'd1;
              end
            end
            PH_DATA: begin
              res_d.status = silf_pkg::STAT_DATA;
              res_d.addr = load_base_q + 64'(idx_q);
              res_d.data = s_axis_tdata;
              div_start = 1'b1;
              state_d = S_DIV;
            end
            default: begin
              magic_sr_d = magic_shift;
              phase_d = PH_MAGIC;
              if (hdr_cnt_q == silf_pkg::HDR_LAST) begin
                hdr_cnt_d = '0;
                if (magic_shift != magic_word_q) begin
                  res_d.status = silf_pkg::STAT_BAD_MAGIC;
                end else begin
                  phase_d = PH_LENGTH;
                end
              end else begin
                hdr_cnt_d = hdr_cnt_q + 2'd1;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if ((div_res.quotient != last_pct_q) && silf_pkg::is_tenth(div_res.quotient)) begin
            last_pct_d = div_res.quotient;
            res_d.pvalid = 1'b1;
            res_d.pct = div_res.quotient;
          end
          if (idx_next == len_sr_q[LB-1:0]) begin
            res_d.done = 1'b1;
            phase_d = PH_MAGIC;
            hdr_cnt_d = '0;
            idx_d = '0;
          end else begin
            idx_d = idx_next;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          out_d = res_q;
          m_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_MAGIC;
      hdr_cnt_q <= '0;
      magic_sr_q <= '0;
      len_sr_q <= '0;
      idx_q <= '0;
      last_pct_q <= silf_pkg::PCT_NONE;
      magic_word_q <= '0;
      load_base_q <= '0;
      res_q <= '0;
      out_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      magic_sr_q <= magic_sr_d;
      len_sr_q <= len_sr_d;
      idx_q <= idx_d;
      last_pct_q <= last_pct_d;
      res_q <= res_d;
      out_q <= out_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i && (cfg_idx_i == silf_pkg::CFG_MAGIC_WORD)) begin
        magic_word_q <= cfg_data_i[31:0];
      end
      if (cfg_we_i && (cfg_idx_i == silf_pkg::CFG_LOAD_BASE)) begin
        load_base_q <= cfg_data_i;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = {1'b0, out_q.pct, out_q.data, out_q.addr};
  assign m_axis_tuser = {out_q.pvalid, out_q.status};
  assign m_axis_tlast = out_q.done;

  `SILF_NEVER(a_no_accept_in_div, s_axis_tready && div_res.busy, "item accepted while dividing")
  `SILF_ASSERT(a_len_nonzero, (phase_q == PH_DATA) |-> (len_sr_q[LB-1:0] != '0), "zero length")
  `SILF_ASSERT(a_pct_range, out_q.pvalid |-> (out_q.pct <= silf_pkg::PCT_FULL), "bad percent")

endmodule

`default_nettype wire

/* dv/serial_image_load_framer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial image load framer testbench
// Sends boot image byte streams into the framer: a directed table first
// (empty image, bad magic, a short load), then random phases made mostly of
// well-formed images with random lengths and content, mixed with broken magic
// words and noise. Each phase writes new register values, including a wrapping
// load base and an unused register index. A byte-level predictor derives the
// result of every accepted item, and each output item is checked against the
// oldest pending result. Sender gaps, receiver stalls and a long receiver
// hold-off vary from phase to phase.
// ----------------------------------------------------------------------------

module serial_image_load_framer_tb;
  import silf_pkg::*;

  localparam int unsigned LENGTH_BITS = 32;
  localparam logic [31:0] LEN_MASK = 32'(((64'd1 << LENGTH_BITS) - 64'd1));
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_CYCLES = 300;
  localparam longint LIMIT_NS = 64'd8_000_000;

  typedef enum logic [1:0] {
    LD_MAGIC  = 2'd0,
    LD_LENGTH = 2'd1,
    LD_DATA   = 2'd2
  } load_phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    result_t    res;
  } table_row_t;

  localparam result_t R_HDR   = '{STAT_HEADER, 64'd0, 8'd0, 1'b0, 7'd0, 1'b0};
  localparam result_t R_BAD   = '{STAT_BAD_MAGIC, 64'd0, 8'd0, 1'b0, 7'd0, 1'b0};
  localparam result_t R_EMPTY = '{STAT_EMPTY, 64'd0, 8'd0, 1'b0, 7'd0, 1'b1};
  localparam result_t R_PRED  = '0;

  localparam int DIR_ROWS = 22;
  localparam table_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_EMPTY},
    '{8'hFF, 1'b1, R_HDR}, '{8'hFF, 1'b1, R_HDR}, '{8'hFF, 1'b1, R_HDR},
    '{8'hFF, 1'b1, R_BAD},
    '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR},
    '{8'h02, 1'b0, R_PRED}, '{8'h00, 1'b0, R_PRED}, '{8'h00, 1'b0, R_PRED},
    '{8'h00, 1'b0, R_PRED},
    '{8'h80, 1'b0, R_PRED}, '{8'h7F, 1'b0, R_PRED}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [63:0]          cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [79:0]          m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  serial_image_load_framer #(
    .LENGTH_BITS(LENGTH_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Predictor state and register copies.
  load_phase_e load_ph    = LD_MAGIC;
  logic [1:0]  hdr_cnt    = 2'd0;
  logic [31:0] magic_acc  = 32'd0;
  logic [31:0] img_len    = 32'd0;
  logic [31:0] byte_idx   = 32'd0;
  logic [6:0]  last_pct   = PCT_NONE;
  logic [31:0] reg_magic  = 32'd0;
  logic [63:0] reg_base   = 64'd0;

  result_t     pending_results[$];
  table_row_t  typed_rows[$];
  logic [7:0]  tx_bytes[$];
  int          mismatches    = 0;
  int          snd_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  int          rx_hold_len   = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic frame_byte(input logic [7:0] b, output result_t r);
    logic [32:0] nxt;
    logic [63:0] p;
    int unsigned sh;
    r  = '0;
    sh = hdr_cnt * 8;
    case (load_ph)
      LD_LENGTH: begin
        img_len[sh +: 8] = b;
        if (hdr_cnt == HDR_LAST) begin
          hdr_cnt  = 2'd0;
          img_len  = img_len & LEN_MASK;
          byte_idx = 32'd0;
          last_pct = PCT_NONE;
          if (img_len == 32'd0) begin
            r.status = STAT_EMPTY;
            r.done   = 1'b1;
            load_ph  = LD_MAGIC;
          end else begin
            load_ph = LD_DATA;
          end
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
      end
      LD_DATA: begin
        nxt      = {1'b0, byte_idx} + 33'd1;
        r.status = STAT_DATA;
        r.addr   = reg_base + {32'd0, byte_idx};
        r.data   = b;
        p        = 64'd0;
        if (img_len != 32'd0) p = ({31'd0, nxt} * 64'd100) / {32'd0, img_len};
        if (p > 64'd127) p = 64'd127;
        if (p[6:0] != last_pct && (p % 64'd10) == 64'd0) begin
          last_pct = p[6:0];
          r.pvalid = 1'b1;
          r.pct    = p[6:0];
        end
        if (nxt >= {1'b0, img_len}) begin
          r.done   = 1'b1;
          load_ph  = LD_MAGIC;
          hdr_cnt  = 2'd0;
          byte_idx = 32'd0;
        end else begin
          byte_idx = nxt[31:0];
        end
      end
      default: begin
        magic_acc[sh +: 8] = b;
        if (hdr_cnt == HDR_LAST) begin
          hdr_cnt = 2'd0;
          if (magic_acc != reg_magic) begin
            r.status = STAT_BAD_MAGIC;
            load_ph  = LD_MAGIC;
          end else begin
            img_len = 32'd0;
            load_ph = LD_LENGTH;
          end
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
          load_ph = LD_MAGIC;
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin : in_mon
    result_t    pred;
    table_row_t row;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAGIC_WORD) reg_magic = cfg_data_i[31:0];
        else if (cfg_idx_i == CFG_LOAD_BASE) reg_base = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        frame_byte(s_axis_tdata, pred);
        if (typed_rows.size() != 0) begin
          row = typed_rows.pop_front();
          if (row.typed) pred = row.res;
        end
        pending_results.push_back(pred);
      end
    end
  end

  always @(posedge clk_i) begin : out_mon
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser[1:0];
      got.pvalid = m_axis_tuser[2];
      got.addr   = m_axis_tdata[63:0];
      got.data   = m_axis_tdata[71:64];
      got.pct    = m_axis_tdata[78:72];
      got.done   = m_axis_tlast;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected: status=%0d addr=%h data=%h pv=%b pct=%0d done=%b",
                   $realtime, got.status, got.addr, got.data, got.pvalid, got.pct, got.done);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.addr !== want.addr ||
            got.data !== want.data || got.pvalid !== want.pvalid ||
            got.pct !== want.pct || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t mismatch: exp status=%0d addr=%h data=%h pv=%b pct=%0d done=%b",
                     $realtime, want.status, want.addr, want.data, want.pvalid, want.pct,
                     want.done);
            $display("%0t           got status=%0d addr=%h data=%h pv=%b pct=%0d done=%b",
                     $realtime, got.status, got.addr, got.data, got.pvalid, got.pct,
                     got.done);
          end
        end
      end
    end
  end

  initial begin : rx_side
    int hold;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        hold        = rx_hold_len;
        rx_hold_len = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) tx_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic push_image(input logic [31:0] magic, input logic [31:0] len,
                            input int ndata);
    push_word(magic);
    push_word(len);
    repeat (ndata) tx_bytes.push_back(8'($urandom));
  endtask

  initial begin : main
    int                   sent;
    int                   kind;
    int                   len;
    logic [31:0]          cur_magic;
    logic [63:0]          base;
    logic [CFG_IDX_W-1:0] spare_idx;
    rst_ni = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_MAGIC_WORD;
    cfg_data_i    <= 64'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_rows.push_back(DIR_TAB[i]);
      send_byte(DIR_TAB[i].b);
    end
    drain();

    for (int pi = 0; pi < PHASES; pi++) begin
      cur_magic = $urandom;
      base      = {$urandom, $urandom};
      case (pi)
        0: begin
          cur_magic = '1;
          base      = 64'hFFFF_FFFF_FFFF_FFF0;
          snd_idle_pct = 0;  rcv_stall_pct = 0;
        end
        1: begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
        2: begin
          cur_magic = '0;
          base      = '0;
          snd_idle_pct = 0;  rcv_stall_pct = 68;
        end
        3: begin snd_idle_pct = 32; rcv_stall_pct = 32; end
        4: begin
          base = '1;
          snd_idle_pct = 0;  rcv_stall_pct = 0;
        end
        default: begin snd_idle_pct = 32; rcv_stall_pct = 32; end
      endcase
      spare_idx = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_LOAD_BASE + 1));
      write_reg(CFG_MAGIC_WORD, {$urandom, cur_magic});
      write_reg(CFG_LOAD_BASE, base);
      write_reg(spare_idx, {$urandom, $urandom});
      if (pi == 0) rx_hold_len = HOLD_CYCLES;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          len = $urandom_range(24, 1);
          push_image(cur_magic, len, len);
        end else if (kind < 70) begin
          len = $urandom_range(160, 90);
          push_image(cur_magic, len, len);
        end else if (kind < 78) begin
          push_image(cur_magic, 32'd0, 0);
        end else if (kind < 88) begin
          push_word(cur_magic ^ (32'($urandom_range(255, 1)) << (8 * $urandom_range(3))));
        end else begin
          push_word($urandom);
        end
        if (pi == PHASES - 1 && sent + tx_bytes.size() >= PHASE_ITEMS)
          push_image(cur_magic, LEN_MASK, 20);
        while (tx_bytes.size() != 0) begin
          send_byte(tx_bytes.pop_front());
          sent++;
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/silf_pkg.sv
src/silf_pct_div.sv
src/serial_image_load_framer.sv
dv/serial_image_load_framer_tb.sv
